/* rtl/core/lzwcd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW code decoder package
// Shared widths, codes, the command that travels from the front to the back,
// and the dictionary write beat.
// ----------------------------------------------------------------------------
package lzwcd_pkg;

	localparam int CODE_BITS  = 12;
	localparam int DICT_SIZE  = 1 << CODE_BITS;
	localparam int MAX_STRING = 64;
	localparam int LEN_W      = 7;
	localparam int IDX_W      = 6;

	typedef logic [CODE_BITS-1:0] code_t;
	typedef logic [LEN_W-1:0]     len_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [7:0]           byte_t;

	localparam code_t ALPHABET_CODE = code_t'(256);
	localparam code_t RESET_CODE    = code_t'(DICT_SIZE - 1);
	localparam len_t  MAX_LEN       = len_t'(MAX_STRING);

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_INVALID   = 2'd1,
		STATUS_NOT_ADDED = 2'd2
	} status_t;

	// One decode job: the code whose chain is walked and its string length.
	typedef struct packed {
		logic    err;
		status_t status;
		code_t   code;
		len_t    len;
	} cmd_t;

	typedef struct packed {
		logic  en;
		code_t addr;
		code_t prefix;
		byte_t suffix;
	} dict_wr_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_WALK,
		BK_LAST,
		BK_EMIT
	} back_state_t;

endpackage

/* rtl/core/lzwcd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW decoder front
// Accepts codes, checks them, keeps the dictionary bookkeeping and issues one
// decode command per code other than a reset code to the command queue.
// ----------------------------------------------------------------------------
module lzwcd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  lzwcd_pkg::code_t    code_word,
	output logic                push,
	output lzwcd_pkg::cmd_t     cmd,
	input  logic                q_full,
	input  logic                back_quiet,
	output lzwcd_pkg::dict_wr_t dict_wr
);

	// Length and first byte of every dictionary entry.
	lzwcd_pkg::len_t  len_mem   [lzwcd_pkg::DICT_SIZE];
	lzwcd_pkg::byte_t first_mem [lzwcd_pkg::DICT_SIZE];

	logic             busy_q;
	lzwcd_pkg::code_t code_s1;
	lzwcd_pkg::len_t  rd_len_s1;
	lzwcd_pkg::byte_t rd_first_s1;
	lzwcd_pkg::code_t nf_q;
	lzwcd_pkg::code_t prev_code_q;
	lzwcd_pkg::len_t  prev_len_q;
	lzwcd_pkg::byte_t prev_first_q;
	logic             have_prev_q;

	logic             accept;
	logic             is_reset;
	logic             lit;
	logic             valid_c;
	logic             full_flag;
	logic             add;
	logic             fire;
	logic             reset_go;
	lzwcd_pkg::len_t  newlen;
	lzwcd_pkg::len_t  cur_len;
	lzwcd_pkg::byte_t cur_first;

	assign accept   = in_valid && !busy_q;
	assign in_stall = busy_q;

	// Classification of the held code.
	always_comb begin
		is_reset = (code_s1 == lzwcd_pkg::RESET_CODE);
		lit      = (code_s1 < lzwcd_pkg::ALPHABET_CODE);
		newlen   = prev_len_q + lzwcd_pkg::len_t'(1);
		if (!have_prev_q) begin
			valid_c = lit;
		end else begin
			valid_c = lit || (code_s1 < nf_q) ||
				((code_s1 == nf_q) && (prev_len_q < lzwcd_pkg::MAX_LEN));
		end
		if (lit) begin
			cur_len   = lzwcd_pkg::len_t'(1);
			cur_first = code_s1[7:0];
		end else if (code_s1 == nf_q) begin
			cur_len   = newlen;
			cur_first = prev_first_q;
		end else begin
			cur_len   = rd_len_s1;
			cur_first = rd_first_s1;
		end
		full_flag = have_prev_q &&
			((nf_q == lzwcd_pkg::RESET_CODE) || (newlen > lzwcd_pkg::MAX_LEN));
		add      = valid_c && have_prev_q && !full_flag;
		fire     = busy_q && !is_reset && !q_full;
		reset_go = busy_q && is_reset && back_quiet;
		push     = fire;

		cmd.err  = !valid_c;
		cmd.code = code_s1;
		cmd.len  = cur_len;
		if (!valid_c) begin
			cmd.status = lzwcd_pkg::STATUS_INVALID;
		end else if (full_flag) begin
			cmd.status = lzwcd_pkg::STATUS_NOT_ADDED;
		end else begin
			cmd.status = lzwcd_pkg::STATUS_OK;
		end

		dict_wr.en     = fire && add;
		dict_wr.addr   = nf_q;
		dict_wr.prefix = prev_code_q;
		dict_wr.suffix = cur_first;
	end

	// Control state and the previous string.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			nf_q         <= lzwcd_pkg::ALPHABET_CODE;
			prev_code_q  <= '0;
			prev_len_q   <= '0;
			prev_first_q <= '0;
			have_prev_q  <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (fire || reset_go) begin
				busy_q <= 1'b0;
			end
			if (reset_go) begin
				nf_q        <= lzwcd_pkg::ALPHABET_CODE;
				prev_code_q <= '0;
				have_prev_q <= 1'b0;
			end else if (fire && valid_c) begin
				prev_code_q  <= code_s1;
				prev_len_q   <= cur_len;
				prev_first_q <= cur_first;
				have_prev_q  <= 1'b1;
				if (add) begin
					nf_q <= nf_q + lzwcd_pkg::code_t'(1);
				end
			end
		end
	end

	// Table lookup of the incoming code and the new entry write.
	always_ff @(posedge clk) begin
		if (accept) begin
			code_s1     <= code_word;
			rd_len_s1   <= len_mem[code_word];
			rd_first_s1 <= first_mem[code_word];
		end
		if (fire && add) begin
			len_mem[nf_q]   <= newlen;
			first_mem[nf_q] <= prev_first_q;
		end
	end

endmodule

/* rtl/core/lzwcd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW decoder command queue
// Two-entry queue of decode commands between the front and the back.
// ----------------------------------------------------------------------------
module lzwcd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lzwcd_pkg::cmd_t push_data,
	input  logic            pop,
	output lzwcd_pkg::cmd_t pop_data,
	output logic            full,
	output logic            empty
);

	lzwcd_pkg::cmd_t slot_q [2];
	logic            wptr_q;
	logic            rptr_q;
	logic [1:0]      cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_data = slot_q[rptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Command storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_data;
		end
	end

endmodule

/* rtl/core/lzwcd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW decoder back
// Walks the prefix chain of each command one entry per cycle into a reverse
// stack, then reads the stack out in string order through a small result queue.
// ----------------------------------------------------------------------------
module lzwcd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  lzwcd_pkg::cmd_t     cmd,
	input  logic                q_empty,
	output logic                pop,
	output logic                walking,
	input  lzwcd_pkg::dict_wr_t dict_wr,
	output logic                out_valid,
	input  logic                out_stall,
	output lzwcd_pkg::byte_t    out_byte,
	output logic                last_of_run,
	output logic [1:0]          status
);

	lzwcd_pkg::code_t prefix_mem [lzwcd_pkg::DICT_SIZE];
	lzwcd_pkg::byte_t suffix_mem [lzwcd_pkg::DICT_SIZE];
	lzwcd_pkg::byte_t stack_mem  [lzwcd_pkg::MAX_STRING];

	lzwcd_pkg::back_state_t state_q, state_d;
	lzwcd_pkg::code_t       pre_rd_s1;
	lzwcd_pkg::byte_t       suf_rd_s1;
	lzwcd_pkg::code_t       rd_addr;
	lzwcd_pkg::idx_t        idx_q;
	lzwcd_pkg::byte_t       hold_q;
	lzwcd_pkg::len_t        len_q;
	lzwcd_pkg::status_t     status_q;
	lzwcd_pkg::idx_t        rptr_q;

	logic                   st_we;
	lzwcd_pkg::idx_t        st_addr;
	lzwcd_pkg::byte_t       st_data;
	logic                   issue;
	logic                   issue_last;

	lzwcd_pkg::byte_t       stack_rd_s1;
	logic                   inflight_s1;
	logic                   infl_last_s1;
	lzwcd_pkg::status_t     infl_stat_s1;

	lzwcd_pkg::byte_t       fifo_byte_q [4];
	logic                   fifo_last_q [4];
	lzwcd_pkg::status_t     fifo_stat_q [4];
	logic [1:0]             fwptr_q;
	logic [1:0]             frptr_q;
	logic [2:0]             fcnt_q;
	logic                   fpop;

	assign walking    = (state_q == lzwcd_pkg::BK_WALK) || (state_q == lzwcd_pkg::BK_LAST);
	assign issue      = (state_q == lzwcd_pkg::BK_EMIT) &&
		((fcnt_q + {2'b00, inflight_s1}) <= 3'd2);
	assign issue_last = ({1'b0, rptr_q} == (len_q - lzwcd_pkg::len_t'(1)));

	// Next state, stack writes and chain read address.
	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		st_we   = 1'b0;
		st_addr = idx_q;
		st_data = suf_rd_s1;
		rd_addr = pre_rd_s1;
		unique case (state_q)
			lzwcd_pkg::BK_IDLE: begin
				rd_addr = cmd.code;
				if (!q_empty) begin
					pop = 1'b1;
					if (cmd.err) begin
						st_we   = 1'b1;
						st_addr = '0;
						st_data = '0;
						state_d = lzwcd_pkg::BK_EMIT;
					end else if (cmd.code < lzwcd_pkg::ALPHABET_CODE) begin
						st_we   = 1'b1;
						st_addr = '0;
						st_data = cmd.code[7:0];
						state_d = lzwcd_pkg::BK_EMIT;
					end else begin
						state_d = lzwcd_pkg::BK_WALK;
					end
				end
			end
			lzwcd_pkg::BK_WALK: begin
				st_we = 1'b1;
				if (pre_rd_s1 < lzwcd_pkg::ALPHABET_CODE) begin
					state_d = lzwcd_pkg::BK_LAST;
				end
			end
			lzwcd_pkg::BK_LAST: begin
				st_we   = 1'b1;
				st_data = hold_q;
				state_d = lzwcd_pkg::BK_EMIT;
			end
			lzwcd_pkg::BK_EMIT: begin
				if (issue && issue_last) begin
					state_d = lzwcd_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = lzwcd_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lzwcd_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Walk and read-out counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			hold_q   <= '0;
			len_q    <= '0;
			status_q <= lzwcd_pkg::STATUS_OK;
			rptr_q   <= '0;
		end else begin
			unique case (state_q)
				lzwcd_pkg::BK_IDLE: begin
					rptr_q <= '0;
					if (!q_empty) begin
						status_q <= cmd.status;
						len_q    <= cmd.err ? lzwcd_pkg::len_t'(1) : cmd.len;
						idx_q    <= lzwcd_pkg::idx_t'(cmd.len - lzwcd_pkg::len_t'(1));
					end
				end
				lzwcd_pkg::BK_WALK: begin
					idx_q  <= idx_q - lzwcd_pkg::idx_t'(1);
					hold_q <= pre_rd_s1[7:0];
				end
				lzwcd_pkg::BK_LAST: begin
					rptr_q <= '0;
				end
				lzwcd_pkg::BK_EMIT: begin
					if (issue) begin
						rptr_q <= rptr_q + lzwcd_pkg::idx_t'(1);
					end
				end
				default: begin
					rptr_q <= '0;
				end
			endcase
		end
	end

	// Dictionary chain memories and the reverse stack.
	always_ff @(posedge clk) begin
		if (dict_wr.en) begin
			prefix_mem[dict_wr.addr] <= dict_wr.prefix;
			suffix_mem[dict_wr.addr] <= dict_wr.suffix;
		end
		pre_rd_s1 <= prefix_mem[rd_addr];
		suf_rd_s1 <= suffix_mem[rd_addr];
		if (st_we) begin
			stack_mem[st_addr] <= st_data;
		end
		if (issue) begin
			stack_rd_s1 <= stack_mem[rptr_q];
		end
		infl_last_s1 <= issue_last;
		infl_stat_s1 <= status_q;
	end

	// Result queue: a stack read is only issued when a slot is sure to be free.
	assign fpop        = (fcnt_q != 3'd0) && !out_stall;
	assign out_valid   = (fcnt_q != 3'd0);
	assign out_byte    = fifo_byte_q[frptr_q];
	assign last_of_run = fifo_last_q[frptr_q];
	assign status      = fifo_stat_q[frptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_s1 <= 1'b0;
			fwptr_q     <= '0;
			frptr_q     <= '0;
			fcnt_q      <= '0;
		end else begin
			inflight_s1 <= issue;
			if (inflight_s1) begin
				fwptr_q <= fwptr_q + 2'd1;
			end
			if (fpop) begin
				frptr_q <= frptr_q + 2'd1;
			end
			if (inflight_s1 && !fpop) begin
				fcnt_q <= fcnt_q + 3'd1;
			end else if (fpop && !inflight_s1) begin
				fcnt_q <= fcnt_q - 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (inflight_s1) begin
			fifo_byte_q[fwptr_q] <= stack_rd_s1;
			fifo_last_q[fwptr_q] <= infl_last_s1;
			fifo_stat_q[fwptr_q] <= infl_stat_s1;
		end
	end

endmodule

/* rtl/core/lzw_code_decoder_unit.sv */
// The chain walk takes one dictionary entry per cycle, then the string leaves
// at one byte per cycle while out_stall is low. The front holds one code at a
// time and takes no new code before it is done with the held one.
// Reset is asynchronous and active low: the dictionary is emptied, no memory is cleared.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW code decoder
// Top level: front classifier, command queue and chain-walking back end.
// ----------------------------------------------------------------------------
module lzw_code_decoder_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [11:0]            code_word,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [7:0]             out_byte,
	output logic                   last_of_run,
	output logic [1:0]             status
);

	lzwcd_pkg::cmd_t     push_cmd;
	lzwcd_pkg::cmd_t     pop_cmd;
	lzwcd_pkg::dict_wr_t dict_wr;
	logic                push;
	logic                pop;
	logic                q_full;
	logic                q_empty;
	logic                walking;
	logic                back_quiet;

	// A dictionary reset waits until no older chain is being walked.
	assign back_quiet = q_empty && !walking;

	lzwcd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.code_word  (code_word),
		.push       (push),
		.cmd        (push_cmd),
		.q_full     (q_full),
		.back_quiet (back_quiet),
		.dict_wr    (dict_wr)
	);

	lzwcd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.pop       (pop),
		.pop_data  (pop_cmd),
		.full      (q_full),
		.empty     (q_empty)
	);

	lzwcd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (pop_cmd),
		.q_empty     (q_empty),
		.pop         (pop),
		.walking     (walking),
		.dict_wr     (dict_wr),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.status      (status)
	);

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW code decoder testbench
// Drives LZW codes into the decoder and predicts each decoded byte with a
// dictionary model of its own. Directed tests cover single bytes, dictionary
// growth, the repeated-string case, invalid codes, reset codes and overlong
// strings. Random tests send mostly well-formed streams, with broken codes
// mixed in, and restart a stream after a dictionary reset.
// ----------------------------------------------------------------------------
module tb;

	typedef struct packed {
		lzwcd_pkg::byte_t   data;
		logic               last;
		lzwcd_pkg::status_t st;
	} dec_beat_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [11:0] code_word;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_byte;
	logic        last_of_run;
	logic [1:0]  status;

	// Dictionary model
	lzwcd_pkg::code_t m_prefix [lzwcd_pkg::DICT_SIZE];
	lzwcd_pkg::byte_t m_suffix [lzwcd_pkg::DICT_SIZE];
	lzwcd_pkg::byte_t m_first  [lzwcd_pkg::DICT_SIZE];
	int               m_len    [lzwcd_pkg::DICT_SIZE];
	int               m_next_free;
	int               m_prev;
	bit               m_have_prev;
	dec_beat_t        pending_bytes [$];

	int        n_errors;
	int        n_codes;
	int        n_bytes;
	int        n_invalid;
	int        n_not_added;
	longint    cycle_count;
	bit        random_idle;

	lzw_code_decoder_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.code_word  (code_word),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.last_of_run(last_of_run),
		.status     (status)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Cycle limit: the slowest correct run stays far below this.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 64'd3000000) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic int str_len_of(int c);
		return (c < 256) ? 1 : m_len[c];
	endfunction

	function automatic lzwcd_pkg::byte_t str_first_of(int c);
		return (c < 256) ? lzwcd_pkg::byte_t'(c) : m_first[c];
	endfunction

	// Expand a code into its string, first byte first.
	function automatic void expand(int c, ref lzwcd_pkg::byte_t s [$]);
		s.delete();
		while (s.size() < lzwcd_pkg::MAX_STRING) begin
			if (c < 256) begin
				s.push_front(lzwcd_pkg::byte_t'(c));
				break;
			end
			s.push_front(m_suffix[c]);
			c = m_prefix[c];
		end
	endfunction

	// Predict the decoded beats for one accepted code.
	task automatic predict_decode(logic [11:0] raw);
		int                 c;
		bit                 ok;
		bit                 kwk;
		lzwcd_pkg::byte_t   s [$];
		lzwcd_pkg::byte_t   cur_first;
		lzwcd_pkg::status_t st;
		int                 newlen;
		dec_beat_t          b;
		c = raw;
		ok = 0;
		kwk = 0;
		st = lzwcd_pkg::STATUS_OK;
		if (c == int'(lzwcd_pkg::RESET_CODE)) begin
			m_next_free = 256;
			m_prev = 0;
			m_have_prev = 0;
			return;
		end
		if (!m_have_prev)
			ok = (c < 256);
		else if (c < m_next_free)
			ok = 1;
		else if (c == m_next_free && str_len_of(m_prev) + 1 <= lzwcd_pkg::MAX_STRING) begin
			ok = 1;
			kwk = 1;
		end
		if (!ok) begin
			b.data = 8'd0;
			b.last = 1'b1;
			b.st = lzwcd_pkg::STATUS_INVALID;
			pending_bytes.push_back(b);
			n_invalid++;
			return;
		end
		if (kwk) begin
			expand(m_prev, s);
			cur_first = str_first_of(m_prev);
			if (s.size() < lzwcd_pkg::MAX_STRING)
				s.push_back(cur_first);
		end else begin
			expand(c, s);
			cur_first = str_first_of(c);
		end
		if (m_have_prev) begin
			newlen = str_len_of(m_prev) + 1;
			if (m_next_free >= int'(lzwcd_pkg::RESET_CODE) ||
				newlen > lzwcd_pkg::MAX_STRING) begin
				st = lzwcd_pkg::STATUS_NOT_ADDED;
				n_not_added++;
			end else begin
				m_prefix[m_next_free] = lzwcd_pkg::code_t'(m_prev);
				m_suffix[m_next_free] = cur_first;
				m_first[m_next_free] = str_first_of(m_prev);
				m_len[m_next_free] = newlen;
				m_next_free++;
			end
		end
		m_prev = c;
		m_have_prev = 1;
		foreach (s[i]) begin
			b.data = s[i];
			b.last = (i == s.size() - 1);
			b.st = st;
			pending_bytes.push_back(b);
		end
	endtask

	task automatic report_mismatch(string what, int got, int want);
		$display("Mismatch at cycle %0d: %s got %0h, expected %0h",
			cycle_count, what, got, want);
		n_errors++;
	endtask

	// Send one code; it is predicted when the beat is accepted. Valid stays
	// high after acceptance unless an idle gap follows.
	task automatic send_code(logic [11:0] c);
		int gap;
		gap = random_idle ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		code_word <= c;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_decode(c);
		n_codes++;
	endtask

	// Output stall: a fresh wait is drawn for every beat.
	initial begin
		int wait_left;
		out_stall = 1'b1;
		wait_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				wait_left = random_idle ? $urandom_range(0, 13) : 0;
			else if (wait_left > 0)
				wait_left--;
			out_stall <= (wait_left > 0);
		end
	end

	// Result checker
	always @(posedge clk) begin
		dec_beat_t w;
		if (arst_n && out_valid && !out_stall) begin
			n_bytes++;
			if (pending_bytes.size() == 0) begin
				report_mismatch("unexpected beat, byte", out_byte, 0);
			end else begin
				w = pending_bytes.pop_front();
				if (out_byte !== w.data)
					report_mismatch("out_byte", out_byte, w.data);
				if (last_of_run !== w.last)
					report_mismatch("last_of_run", last_of_run, w.last);
				if (status !== w.st)
					report_mismatch("status", status, w.st);
			end
		end
	end

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	// Directed: single bytes, growth, the repeated-string case, bad codes.
	task automatic test_directed();
		random_idle = 0;
		send_code(12'd0);
		send_code(12'd255);
		send_code(12'd256);
		send_code(12'd258);
		send_code(12'd259);
		send_code(12'd300);
		send_code(12'hFFF);
		send_code(12'd256);
		send_code(12'd65);
		send_code(12'd66);
		send_code(12'd256);
		send_code(12'd258);
		send_code(12'hFFF);
		send_code(12'hFFF);
		send_code(12'd128);
		send_code(12'd257);
		send_code(12'hFFE);
		drain();
	endtask

	// Repeated KwKwK lengthens strings until the maximum is hit; a byte after
	// the longest string cannot add its entry.
	task automatic test_long_strings();
		random_idle = 1;
		send_code(12'hFFF);
		send_code(12'hAA);
		for (int i = 0; i < 70; i++)
			send_code(12'(m_next_free));
		send_code(12'h41);
		drain();
	endtask

	function automatic logic [11:0] pick_code();
		int r;
		r = $urandom_range(0, 99);
		if (!m_have_prev || r < 40)
			return 12'($urandom_range(0, 255));
		if (r < 85 && m_next_free > 256)
			return 12'($urandom_range(256, m_next_free - 1));
		if (r < 93)
			return 12'(m_next_free);
		if (r < 96)
			return 12'hFFF;
		return 12'($urandom_range(0, 4094));
	endfunction

	task automatic test_random();
		random_idle = 1;
		for (int i = 0; i < 300; i++) begin
			if (i % 16 == 8)
				random_idle = 0;
			else if (i % 16 == 0)
				random_idle = 1;
			send_code(pick_code());
		end
		drain();
	endtask

	// Restart a stream after a dictionary reset.
	task automatic test_restart();
		random_idle = 1;
		send_code(12'hFFF);
		for (int i = 0; i < 60; i++)
			send_code(pick_code());
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		code_word = 12'd0;
		n_errors = 0;
		n_codes = 0;
		n_bytes = 0;
		n_invalid = 0;
		n_not_added = 0;
		cycle_count = 0;
		random_idle = 0;
		m_next_free = 256;
		m_prev = 0;
		m_have_prev = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_long_strings();
		test_random();
		test_restart();
		$display("Covered %0d codes and %0d output bytes.", n_codes, n_bytes);
		$display("Invalid codes %0d, entries not added %0d, mismatches %0d.",
			n_invalid, n_not_added, n_errors);
		if (n_errors == 0 && pending_bytes.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/lzwcd_pkg.sv
rtl/core/lzwcd_front.sv
rtl/core/lzwcd_queue.sv
rtl/core/lzwcd_back.sv
rtl/core/lzw_code_decoder_unit.sv
dv/tb.sv
